### rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// shared types and codes for the stack machine execute core
// ----------------------------------------------------------------------------
package smx_pkg;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_ADD   = 5'd1,
        OP_SUB   = 5'd2,
        OP_MUL   = 5'd3,
        OP_DIV   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_NOT   = 5'd8,
        OP_EQ    = 5'd9,
        OP_LT    = 5'd10,
        OP_GT    = 5'd11,
        OP_LOAD  = 5'd12,
        OP_STORE = 5'd13,
        OP_CALL  = 5'd14,
        OP_RET   = 5'd15,
        OP_OUT   = 5'd16
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_DIV_ZERO  = 3'd2,
        ERR_ADDRESS   = 3'd3,
        ERR_RET_UNDER = 3'd4,
        ERR_OVERFLOW  = 3'd5,
        ERR_CALL_OVER = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EXEC,
        ST_OPERAND,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

    // request to the shared alu
    typedef struct packed {
        logic        start;
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

endpackage

### rtl/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/smx_alu.sv
// ----------------------------------------------------------------------------
// smx_alu
// shared arithmetic unit; registered result for most ops, bit-serial divide
// ----------------------------------------------------------------------------
module smx_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  smx_pkg::alu_req_t req,
    output smx_pkg::alu_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] mag_a, mag_b;
    logic [63:0] prod;

    assign mag_a = req.a[31] ? (32'd0 - req.a) : req.a;
    assign mag_b = req.b[31] ? (32'd0 - req.b) : req.b;
    assign prod  = req.a * req.b;
    assign trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            // restoring divide, one quotient bit a cycle
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (32'd0 - quo_next) : quo_next;
            end
        end
        else if (req.start)
        begin
            done_next = 1'b1;
            unique case (smx_pkg::op_t'(req.op))
                smx_pkg::OP_ADD: res_next = req.a + req.b;
                smx_pkg::OP_SUB: res_next = req.a - req.b;
                smx_pkg::OP_MUL: res_next = prod[31:0];
                smx_pkg::OP_AND: res_next = req.a & req.b;
                smx_pkg::OP_OR:  res_next = req.a | req.b;
                smx_pkg::OP_XOR: res_next = req.a ^ req.b;
                smx_pkg::OP_NOT: res_next = ~req.a;
                smx_pkg::OP_EQ:  res_next = {31'd0, req.a == req.b};
                smx_pkg::OP_LT:  res_next = {31'd0, $signed(req.a) < $signed(req.b)};
                smx_pkg::OP_GT:  res_next = {31'd0, $signed(req.a) > $signed(req.b)};
                smx_pkg::OP_DIV:
                begin
                    done_next = 1'b0;
                    busy_next = 1'b1;
                    cnt_next  = 6'd32;
                    quo_next  = mag_a;
                    rem_next  = 33'd0;
                    div_next  = mag_b;
                    neg_next  = req.a[31] ^ req.b[31];
                end
                default: res_next = req.a;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

### rtl/stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// executes one stack machine instruction per item
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  in       | in_valid / in_ready        | op value address target
//  out      | out_ready_valid / out_ready| top_value out_value out_valid
//           |                            | next_pc stack_depth error_code halted
//
// each item is accepted in idle and passes read and exec. push, load, store,
// call, ret, output and unused codes then go to write; the binary ops pass
// operand and the alu wait state before write, and not goes from exec to the
// alu wait state. a faulting item or one taken while halted goes to done.
// the rams have registered reads; the shared alu divides bit-serially.
// after reset the data memory is cleared word by word before the
// first item is taken. the result waits in output registers until taken.
module stack_machine_execute_core #(
    parameter int MEM_DEPTH   = 256,
    parameter int STACK_DEPTH = 256,
    parameter int CALL_DEPTH  = 64,
    parameter int PC_WIDTH    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [4:0]                   op,
    input  logic signed [31:0]           value,
    input  logic signed [31:0]           address,
    input  logic [15:0]                  target,
    output logic                         out_ready_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           top_value,
    output logic signed [31:0]           out_value,
    output logic                         out_valid,
    output logic [PC_WIDTH-1:0]          next_pc,
    output logic [$clog2(STACK_DEPTH):0] stack_depth,
    output logic [2:0]                   error_code,
    output logic                         halted
);

    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CAW = $clog2(CALL_DEPTH);

    smx_pkg::state_t state_reg, state_next;

    logic [SAW:0]        sp_reg, sp_next;
    logic [CAW:0]        rp_reg, rp_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic                halt_reg, halt_next;
    logic [MAW-1:0]      clr_reg, clr_next;
    logic [4:0]          op_reg;
    logic [31:0]         val_reg, addr_reg;
    logic [15:0]         tgt_reg;
    logic [31:0]         b_reg, b_next;
    logic [31:0]         top_reg, top_next;
    logic [31:0]         outv_reg, outv_next;
    logic                outok_reg, outok_next;
    logic [2:0]          err_reg, err_next;

    // ram ports
    logic             ds_we, dm_we, rs_we;
    logic [SAW-1:0]   ds_addr;
    logic [MAW-1:0]   dm_addr;
    logic [CAW-1:0]   rs_addr;
    logic [31:0]      ds_wdata, dm_wdata, ds_rdata, dm_rdata;
    logic [PC_WIDTH-1:0] rs_wdata, rs_rdata;

    smx_pkg::alu_req_t alu_req;
    smx_pkg::alu_rsp_t alu_rsp;

    logic addr_ok, is_bin;
    smx_pkg::op_t opc;

    assign opc     = smx_pkg::op_t'(op_reg);
    assign addr_ok = !addr_reg[31] && (addr_reg < 32'(MEM_DEPTH));
    assign is_bin  = (op_reg >= smx_pkg::OP_ADD) && (op_reg <= smx_pkg::OP_GT)
                     && (op_reg != smx_pkg::OP_NOT);

    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_dstack (
        .clk(clk), .we(ds_we), .addr(ds_addr), .wdata(ds_wdata), .rdata(ds_rdata));
    smx_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk(clk), .we(dm_we), .addr(dm_addr), .wdata(dm_wdata), .rdata(dm_rdata));
    smx_ram #(.WIDTH(PC_WIDTH), .DEPTH(CALL_DEPTH)) u_rstack (
        .clk(clk), .we(rs_we), .addr(rs_addr), .wdata(rs_wdata), .rdata(rs_rdata));

    smx_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smx_pkg::ST_CLEAR:
                if (clr_reg == MAW'(MEM_DEPTH - 1)) state_next = smx_pkg::ST_IDLE;
            smx_pkg::ST_IDLE:
                if (in_valid) state_next = smx_pkg::ST_READ;
            smx_pkg::ST_READ:
                state_next = smx_pkg::ST_EXEC;
            smx_pkg::ST_EXEC:
                if (halt_reg || err_next != smx_pkg::ERR_NONE)
                    state_next = smx_pkg::ST_DONE;
                else if (is_bin)
                    state_next = smx_pkg::ST_OPERAND;
                else if (opc == smx_pkg::OP_NOT)
                    state_next = smx_pkg::ST_DIV;
                else
                    state_next = smx_pkg::ST_WRITE;
            smx_pkg::ST_OPERAND:
                state_next = smx_pkg::ST_DIV;
            smx_pkg::ST_DIV:
                if (alu_rsp.done) state_next = smx_pkg::ST_WRITE;
            smx_pkg::ST_WRITE:
                state_next = smx_pkg::ST_DONE;
            smx_pkg::ST_DONE:
                if (out_ready) state_next = smx_pkg::ST_IDLE;
            default:
                state_next = smx_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        sp_next    = sp_reg;
        rp_next    = rp_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        clr_next   = clr_reg;
        b_next     = b_reg;
        top_next   = top_reg;
        outv_next  = outv_reg;
        outok_next = outok_reg;
        err_next   = err_reg;
        ds_we = 1'b0; dm_we = 1'b0; rs_we = 1'b0;
        ds_addr  = sp_reg[SAW-1:0] - SAW'(1);
        dm_addr  = addr_reg[MAW-1:0];
        rs_addr  = rp_reg[CAW-1:0] - CAW'(1);
        ds_wdata = 32'd0;
        dm_wdata = 32'd0;
        rs_wdata = pc_reg;
        alu_req  = '0;
        unique case (state_reg)
            smx_pkg::ST_CLEAR:
            begin
                dm_we    = 1'b1;
                dm_addr  = clr_reg;
                clr_next = clr_reg + MAW'(1);
            end
            smx_pkg::ST_IDLE:
            begin
                err_next   = smx_pkg::ERR_NONE;
                outv_next  = 32'd0;
                outok_next = 1'b0;
            end
            smx_pkg::ST_READ:
                // the rams are addressed for top-of-stack, memory and return stack
                ds_addr = sp_reg[SAW-1:0] - SAW'(1);
            smx_pkg::ST_EXEC:
            begin
                // top is on the ram output; read the one below top
                ds_addr = sp_reg[SAW-1:0] - SAW'(2);
                b_next  = ds_rdata;
                if (!halt_reg)
                begin
                    if (is_bin && sp_reg < (SAW+1)'(2))
                        err_next = smx_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        unique case (opc)
                            smx_pkg::OP_PUSH:
                                if (sp_reg >= (SAW+1)'(STACK_DEPTH))
                                    err_next = smx_pkg::ERR_OVERFLOW;
                            smx_pkg::OP_DIV:
                                if (ds_rdata == 32'd0) err_next = smx_pkg::ERR_DIV_ZERO;
                            smx_pkg::OP_NOT, smx_pkg::OP_OUT:
                                if (sp_reg == '0) err_next = smx_pkg::ERR_UNDERFLOW;
                            smx_pkg::OP_LOAD:
                                if (!addr_ok) err_next = smx_pkg::ERR_ADDRESS;
                                else if (sp_reg >= (SAW+1)'(STACK_DEPTH))
                                    err_next = smx_pkg::ERR_OVERFLOW;
                            smx_pkg::OP_STORE:
                                if (!addr_ok) err_next = smx_pkg::ERR_ADDRESS;
                                else if (sp_reg == '0) err_next = smx_pkg::ERR_UNDERFLOW;
                            smx_pkg::OP_CALL:
                                if (rp_reg >= (CAW+1)'(CALL_DEPTH))
                                    err_next = smx_pkg::ERR_CALL_OVER;
                            smx_pkg::OP_RET:
                                if (rp_reg == '0) err_next = smx_pkg::ERR_RET_UNDER;
                            default: ;
                        endcase
                    end
                    if (err_next != smx_pkg::ERR_NONE) halt_next = 1'b1;
                end
                if (opc == smx_pkg::OP_NOT && !halt_reg && sp_reg != '0)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = op_reg;
                    alu_req.a     = ds_rdata;
                end
            end
            smx_pkg::ST_OPERAND:
            begin
                // entry below top is on the ram output now
                alu_req.start = 1'b1;
                alu_req.op    = op_reg;
                alu_req.a     = ds_rdata;
                alu_req.b     = b_reg;
            end
            smx_pkg::ST_DIV: ;
            smx_pkg::ST_WRITE:
            begin
                pc_next = pc_reg + PC_WIDTH'(1);
                if (is_bin)
                begin
                    sp_next  = sp_reg - (SAW+1)'(1);
                    ds_we    = 1'b1;
                    ds_addr  = sp_reg[SAW-1:0] - SAW'(2);
                    ds_wdata = alu_rsp.result;
                    top_next = alu_rsp.result;
                end
                else
                begin
                    unique case (opc)
                        smx_pkg::OP_PUSH:
                        begin
                            ds_we = 1'b1; ds_addr = sp_reg[SAW-1:0];
                            ds_wdata = val_reg; top_next = val_reg;
                            sp_next = sp_reg + (SAW+1)'(1);
                        end
                        smx_pkg::OP_LOAD:
                        begin
                            ds_we = 1'b1; ds_addr = sp_reg[SAW-1:0];
                            ds_wdata = dm_rdata; top_next = dm_rdata;
                            sp_next = sp_reg + (SAW+1)'(1);
                        end
                        smx_pkg::OP_NOT:
                        begin
                            ds_we = 1'b1; ds_wdata = alu_rsp.result;
                            top_next = alu_rsp.result;
                        end
                        smx_pkg::OP_STORE:
                        begin
                            dm_we = 1'b1; dm_wdata = top_reg;
                            sp_next = sp_reg - (SAW+1)'(1);
                            top_next = (sp_reg == (SAW+1)'(1)) ? 32'd0 : ds_rdata;
                        end
                        smx_pkg::OP_OUT:
                        begin
                            outv_next = top_reg; outok_next = 1'b1;
                            sp_next = sp_reg - (SAW+1)'(1);
                            top_next = (sp_reg == (SAW+1)'(1)) ? 32'd0 : ds_rdata;
                        end
                        smx_pkg::OP_CALL:
                        begin
                            rs_we = 1'b1; rs_addr = rp_reg[CAW-1:0];
                            rp_next = rp_reg + (CAW+1)'(1);
                            pc_next = PC_WIDTH'(tgt_reg);
                        end
                        smx_pkg::OP_RET:
                        begin
                            rp_next = rp_reg - (CAW+1)'(1);
                            pc_next = rs_rdata + PC_WIDTH'(1);
                        end
                        default: ;
                    endcase
                end
            end
            smx_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smx_pkg::ST_CLEAR;
            sp_reg    <= '0;
            rp_reg    <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            top_reg   <= 32'd0;
            err_reg   <= smx_pkg::ERR_NONE;
            outok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            rp_reg    <= rp_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            err_reg   <= err_next;
            outok_reg <= outok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == smx_pkg::ST_IDLE && in_valid)
        begin
            op_reg   <= op;
            val_reg  <= value;
            addr_reg <= address;
            tgt_reg  <= target;
        end
        b_reg    <= b_next;
        outv_reg <= outv_next;
    end

    assign in_ready        = (state_reg == smx_pkg::ST_IDLE);
    assign out_ready_valid = (state_reg == smx_pkg::ST_DONE);
    assign top_value       = top_reg;
    assign out_value       = outv_reg;
    assign out_valid       = outok_reg;
    assign next_pc         = pc_reg;
    assign stack_depth     = sp_reg;
    assign error_code      = err_reg;
    assign halted          = halt_reg;

endmodule

### rtl/smx_checker.sv
// ----------------------------------------------------------------------------
// smx_checker
// port level checks for the stack machine execute core
// ----------------------------------------------------------------------------
module smx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_ready_valid,
    input logic        out_ready,
    input logic        out_valid,
    input logic [2:0]  error_code,
    input logic        halted
);

    // a result waits while not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready_valid && !out_ready |=> out_ready_valid)
        else $error("result dropped");

    // no new item while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready_valid |-> !in_ready)
        else $error("accepting with result pending");

    // an error halts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready_valid && error_code != smx_pkg::ERR_NONE |-> halted)
        else $error("error without halt");

    // halt is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        halted |=> halted)
        else $error("halt cleared");

    // output flag only without error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready_valid && out_valid |-> error_code == smx_pkg::ERR_NONE)
        else $error("output with error");

endmodule

bind stack_machine_execute_core smx_checker u_smx_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_ready_valid(out_ready_valid), .out_ready(out_ready),
    .out_valid(out_valid), .error_code(error_code), .halted(halted)
);
